### sv/markov_kmer_count_and_sample_defines.svh
// Assertion macros shared by the checker of the k-mer count and sample block.
// No dependencies; include by bare file name.
`ifndef MARKOV_KMER_COUNT_AND_SAMPLE_DEFINES_SVH
`define MARKOV_KMER_COUNT_AND_SAMPLE_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define MKCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define MKCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define MKCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mkcs_pkg.sv
// Types and constants of the k-mer count and sample block.
// No dependencies; used by the wide arithmetic unit, the top level and the checker.
package mkcs_pkg;

   localparam int BASE_W  = 2;
   localparam int KIND_W  = 2;
   localparam int RAND_W  = 16;
   localparam int NIB_W   = 4;
   localparam int MUL_STEPS = RAND_W / NIB_W;
   localparam int CSR_W   = 2;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

   // operations of the shared wide unit
   typedef enum logic [2:0] {
      UOP_HOLD,
      UOP_INIT,
      UOP_CTX_ADD,
      UOP_MUL,
      UOP_CUM_ADD
   } uop_type;

   // number of counters over all orders: alpha^1 + ... + alpha^(order+1)
   function automatic int kmer_depth(input int alpha, input int order);
      int s;
      int p;
      s = 0;
      p = 1;
      for (int i = 0; i <= order; i++) begin
         p = p * alpha;
         s = s + p;
      end
      return s;
   endfunction

endpackage

### sv/markov_kmer_count_and_sample.sv
// Top level of the k-mer count and sample block: sequencer, count memory, history.
// Depends on mkcs_pkg and mkcs_wide_unit.
//
// Use: drive req_* with start while busy is low; that edge takes the item.
// Kind clear zeroes every count, kind count trains on req_base, kind sample
// draws a base with req_random and returns it on rsp_* for one cycle, marked
// by rsp_valid. There is no back-pressure: the receiver must take each beat.
// csr_we with csr_wdata sets the Markov order; write it only while idle.
// Steps after the accept edge (k = context order):
//   clear  : zeroes all DEPTH counters (84 at defaults), one counter per cycle
//   count  : one read-modify-write per order, for orders 0 through k
//   sample : walk to order k, one context read (k > 0) or ALPHABET reads (k = 0),
//            r * context product by nibbles, then read, add and compare per base
//            examined; rsp_valid shows on the edge that drops busy
// The single count memory port and the shared wide unit serialise these steps.
// Reset is synchronous; after it the block runs the clearing pass over all DEPTH
// counters with busy high, and history, position and order return to defaults.
module markov_kmer_count_and_sample import mkcs_pkg::*; #(
   parameter int ALPHABET   = 4,
   parameter int MAX_ORDER  = 2,
   parameter int COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BASE_W-1:0] req_base,
   input  logic              req_new_sequence,
   input  logic [RAND_W-1:0] req_random,
   output logic              rsp_valid,
   output logic [BASE_W-1:0] rsp_sampled_base,
   output logic              rsp_fell_back,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int DEPTH = kmer_depth(ALPHABET, MAX_ORDER);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PSW   = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
   localparam int OW    = (PSW > CSR_W) ? PSW : CSR_W;
   localparam int HD    = (MAX_ORDER > 0) ? MAX_ORDER : 1;
   localparam int HW    = HD * BASE_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CLEAR   = 4'd1;
   localparam logic [3:0] ST_CNT_RD  = 4'd2;
   localparam logic [3:0] ST_CNT_WR  = 4'd3;
   localparam logic [3:0] ST_WALK    = 4'd4;
   localparam logic [3:0] ST_CTX_RD  = 4'd5;
   localparam logic [3:0] ST_CTX_ACC = 4'd6;
   localparam logic [3:0] ST_MUL     = 4'd7;
   localparam logic [3:0] ST_EXT_RD  = 4'd8;
   localparam logic [3:0] ST_EXT_ACC = 4'd9;
   localparam logic [3:0] ST_EXT_CMP = 4'd10;

   localparam logic [BASE_W-1:0] LAST_BASE = BASE_W'(ALPHABET - 1);
   localparam logic [1:0]        LAST_MUL  = 2'(MUL_STEPS - 1);

   // control registers
   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [OW-1:0]     order_ff, order_in;
   logic [HW-1:0]     hist_ff, hist_in;
   logic [PSW-1:0]    pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [PSW-1:0]    j_ff, j_in;
   logic [PSW-1:0]    top_ff, top_in;
   logic [BASE_W-1:0] a_ff, a_in;
   logic [AW-1:0]     sa_ff, sa_in;
   logic [AW-1:0]     cv_ff, cv_in;
   logic [AW-1:0]     pw_ff, pw_in;
   logic [HW-1:0]     hs_ff, hs_in;
   logic [1:0]        mstep_ff, mstep_in;
   logic [BASE_W-1:0] pick_ff, pick_in;
   logic              fell_ff, fell_in;

   // count memory
   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [AW-1:0]         raddr;
   logic [AW-1:0]         waddr;
   logic [COUNT_BITS-1:0] wdata;
   logic                  we;

   // address and history helpers
   logic [AW-1:0]         cur_addr;
   logic [AW-1:0]         ctx_addr;
   logic [COUNT_BITS-1:0] inc_count;
   logic                  push;
   logic [BASE_W-1:0]     push_base;
   logic [HW+BASE_W-1:0]  hist_cat;
   logic [OW-1:0]         pos_eff;
   logic [OW-1:0]         ord_eff;
   logic [OW-1:0]         ctx_order;
   logic                  base_ok;
   uop_type               uop;
   logic                  le;

   // shared wide unit
   mkcs_wide_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_wide (
      .clock       (clock),
      .op          (uop),
      .random_load (req_random),
      .rdata       (rdata_ff),
      .le          (le)
   );

   // counter address: table start + context * ALPHABET + base offset
   assign cur_addr  = sa_ff + AW'(cv_ff * AW'(ALPHABET)) + AW'(a_ff);
   // context counter lives one table below: start(k-1) + context
   assign ctx_addr  = sa_ff - pw_ff + cv_ff;
   assign inc_count = (&rdata_ff) ? rdata_ff : rdata_ff + COUNT_BITS'(1);

   // context order of an item being accepted
   assign pos_eff   = req_new_sequence ? '0 : OW'(pos_ff);
   assign ord_eff   = (order_ff > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : order_ff;
   assign ctx_order = (pos_eff < ord_eff) ? pos_eff : ord_eff;
   assign base_ok   = ({1'b0, req_base} < (BASE_W+1)'(ALPHABET));

   assign hist_cat  = {hist_ff, push_base};

   // memory port select
   assign raddr = (state_ff == ST_CTX_RD && top_ff != '0) ? ctx_addr : cur_addr;
   assign we    = (state_ff == ST_CLEAR) || (state_ff == ST_CNT_WR);
   assign waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : cur_addr;
   assign wdata = (state_ff == ST_CLEAR) ? '0 : inc_count;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      order_in     = order_ff;
      hist_in      = hist_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      j_in         = j_ff;
      top_in       = top_ff;
      a_in         = a_ff;
      sa_in        = sa_ff;
      cv_in        = cv_ff;
      pw_in        = pw_ff;
      hs_in        = hs_ff;
      mstep_in     = mstep_ff;
      pick_in      = pick_ff;
      fell_in      = fell_ff;
      uop          = UOP_HOLD;
      push         = 1'b0;
      push_base    = a_ff;

      if (csr_we) begin
         order_in = OW'(csr_wdata);
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_new_sequence) begin
                  hist_in = '0;
                  pos_in  = '0;
               end
               hs_in    = req_new_sequence ? '0 : hist_ff;
               top_in   = PSW'(ctx_order);
               j_in     = '0;
               sa_in    = '0;
               cv_in    = '0;
               pw_in    = AW'(1);
               mstep_in = '0;
               a_in     = (req_kind == KIND_COUNT) ? req_base : '0;
               uop      = UOP_INIT;
               case (req_kind)
                  KIND_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  KIND_COUNT: begin
                     if (base_ok) begin
                        state_in = ST_CNT_RD;
                     end
                  end
                  KIND_SAMPLE: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // sweep every counter to zero
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end

         // write back the raised count, then advance one order
         ST_CNT_WR: begin
            if (j_ff == top_ff) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sa_in    = sa_ff + AW'(pw_ff * AW'(ALPHABET));
               cv_in    = cv_ff + AW'(pw_ff * hs_ff[BASE_W-1:0]);
               pw_in    = AW'(pw_ff * AW'(ALPHABET));
               hs_in    = hs_ff >> BASE_W;
               j_in     = j_ff + PSW'(1);
               state_in = ST_CNT_RD;
            end
         end

         // build table start and context for the sample order
         ST_WALK: begin
            if (j_ff == top_ff) begin
               state_in = ST_CTX_RD;
            end else begin
               sa_in = sa_ff + AW'(pw_ff * AW'(ALPHABET));
               cv_in = cv_ff + AW'(pw_ff * hs_ff[BASE_W-1:0]);
               pw_in = AW'(pw_ff * AW'(ALPHABET));
               hs_in = hs_ff >> BASE_W;
               j_in  = j_ff + PSW'(1);
            end
         end

         ST_CTX_RD: begin
            state_in = ST_CTX_ACC;
         end

         // order zero sums all order-0 counts; otherwise one read
         ST_CTX_ACC: begin
            uop = UOP_CTX_ADD;
            if (top_ff == '0 && a_ff != LAST_BASE) begin
               a_in     = a_ff + BASE_W'(1);
               state_in = ST_CTX_RD;
            end else begin
               a_in     = '0;
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            uop      = UOP_MUL;
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == LAST_MUL) begin
               state_in = ST_EXT_RD;
            end
         end

         ST_EXT_RD: begin
            state_in = ST_EXT_ACC;
         end

         ST_EXT_ACC: begin
            uop      = UOP_CUM_ADD;
            state_in = ST_EXT_CMP;
         end

         // stop at the first base whose running sum reaches the draw, else fall back to base 0
         ST_EXT_CMP: begin
            if (le || a_ff == LAST_BASE) begin
               pick_in      = le ? a_ff : '0;
               fell_in      = !le;
               push_base    = le ? a_ff : '0;
               push         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               a_in     = a_ff + BASE_W'(1);
               state_in = ST_EXT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shift the new base into history
      if (push) begin
         hist_in = hist_cat[HW-1:0];
         if (pos_ff < PSW'(MAX_ORDER)) begin
            pos_in = pos_ff + PSW'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         order_ff     <= OW'(MAX_ORDER);
         hist_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         order_ff     <= order_in;
         hist_ff      <= hist_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      top_ff   <= top_in;
      a_ff     <= a_in;
      sa_ff    <= sa_in;
      cv_ff    <= cv_in;
      pw_ff    <= pw_in;
      hs_ff    <= hs_in;
      mstep_ff <= mstep_in;
      pick_ff  <= pick_in;
      fell_ff  <= fell_in;
   end

   // count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sampled_base = pick_ff;
   assign rsp_fell_back    = fell_ff;

endmodule

### sv/mkcs_wide_unit.sv
// Shared wide arithmetic unit: context and cumulative count sums, r * ctx
// product by nibbles, and the inverse-CDF compare. Depends on mkcs_pkg.
module mkcs_wide_unit import mkcs_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  uop_type               op,
   input  logic [RAND_W-1:0]     random_load,
   input  logic [COUNT_BITS-1:0] rdata,
   output logic                  le
);

   localparam int CW = COUNT_BITS + 2;
   localparam int PW = CW + RAND_W;

   logic [CW-1:0]     ctx_ff, ctx_in;
   logic [CW-1:0]     cum_ff, cum_in;
   logic [PW-1:0]     lhs_ff, lhs_in;
   logic [RAND_W-1:0] rnd_ff, rnd_in;
   logic [NIB_W-1:0]  nib;
   logic [CW+NIB_W-1:0] prod;
   logic [PW-1:0]     rhs;

   // one nibble of r times the context count
   assign nib  = rnd_ff[RAND_W-1 -: NIB_W];
   assign prod = (CW+NIB_W)'(ctx_ff) * (CW+NIB_W)'(nib);

   // cum * 65535 as a shift and subtract, then the compare
   assign rhs = {cum_ff, {RAND_W{1'b0}}} - PW'(cum_ff);
   assign le  = (lhs_ff <= rhs);

   // select the operation
   always_comb begin
      ctx_in = ctx_ff;
      cum_in = cum_ff;
      lhs_in = lhs_ff;
      rnd_in = rnd_ff;
      case (op)
         UOP_HOLD: begin
         end
         UOP_INIT: begin
            ctx_in = '0;
            cum_in = '0;
            lhs_in = '0;
            rnd_in = random_load;
         end
         UOP_CTX_ADD: begin
            ctx_in = ctx_ff + CW'(rdata);
         end
         UOP_MUL: begin
            lhs_in = PW'({lhs_ff, {NIB_W{1'b0}}}) + PW'(prod);
            rnd_in = rnd_ff << NIB_W;
         end
         UOP_CUM_ADD: begin
            cum_in = cum_ff + CW'(rdata);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_in;
      cum_ff <= cum_in;
      lhs_ff <= lhs_in;
      rnd_ff <= rnd_in;
   end

endmodule

### sv/mkcs_checker.sv
// Port-level checker of the k-mer count and sample block, bound to the top level.
// Depends on mkcs_pkg and markov_kmer_count_and_sample_defines.svh.
`include "markov_kmer_count_and_sample_defines.svh"

module mkcs_checker import mkcs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [KIND_W-1:0] req_kind,
   input logic              rsp_valid,
   input logic [BASE_W-1:0] rsp_sampled_base,
   input logic              rsp_fell_back
);

   // a result beat closes the item, so the block is free at once
   `MKCS_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result beat while busy")

   // a result beat lasts one cycle
   `MKCS_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")

   // fallback always picks base zero
   `MKCS_ASSERT_SAME(a_fallback_zero, clock, reset, rsp_valid && rsp_fell_back, rsp_sampled_base == '0, "fallback with nonzero base")

   // a taken sample raises busy and is not answered at once
   `MKCS_ASSERT_NEXT(a_sample_busy, clock, reset, start && !busy && req_kind == KIND_SAMPLE, busy && !rsp_valid, "sample finished too early")

   // reset starts the clearing pass
   `MKCS_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, busy, "not busy after reset")

endmodule

bind markov_kmer_count_and_sample mkcs_checker u_mkcs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_sampled_base (rsp_sampled_base),
   .rsp_fell_back    (rsp_fell_back)
);

### test/markov_kmer_count_and_sample_tb.sv
// Self-checking testbench of the k-mer count and sample block: directed rows, then random runs
// over all four order settings, checked beat by beat against an in-bench count table model.
// Depends on mkcs_pkg and markov_kmer_count_and_sample.
module markov_kmer_count_and_sample_tb import mkcs_pkg::*; ();

   localparam int HALF_PERIOD = 10;
   localparam int ALPHA       = 4;
   localparam int ORDER_MAX   = 2;
   localparam int COUNT_W     = 32;
   localparam int N_KMERS     = kmer_depth(ALPHA, ORDER_MAX);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 100;
   localparam int PHASE_ITEMS = 280;
   localparam int N_PHASES    = 6;
   localparam int N_DIRECTED  = 23;
   localparam int PRINT_CAP   = 200;

   // kind code that the block takes and drops
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [RAND_W-1:0] DRAW_TOP    = {RAND_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_TOP  = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              fell;
   } draw_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BASE_W-1:0] base;
      logic              ns;
      logic [RAND_W-1:0] rnd;
      logic              pinned;
      draw_type          pin;
   } stim_row_type;

   localparam draw_type NO_PIN = '0;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [KIND_W-1:0] req_kind;
   logic [BASE_W-1:0] req_base;
   logic              req_new_sequence;
   logic [RAND_W-1:0] req_random;
   logic              rsp_valid;
   logic [BASE_W-1:0] rsp_sampled_base;
   logic              rsp_fell_back;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_wdata;

   markov_kmer_count_and_sample dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_base         (req_base),
      .req_new_sequence (req_new_sequence),
      .req_random       (req_random),
      .rsp_valid        (rsp_valid),
      .rsp_sampled_base (rsp_sampled_base),
      .rsp_fell_back    (rsp_fell_back),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // count table model: tables stacked by order, older bases more significant
   logic [COUNT_W-1:0] kmer_tally [N_KMERS];
   int                 hist_word;
   int                 seq_pos;
   logic [CSR_W-1:0]   order_reg;

   draw_type drawn_q [$];

   int    mismatches = 0;
   int    items_taken = 0;
   int    draws_checked = 0;
   int    fallbacks_seen = 0;
   int    clears_taken = 0;
   int    ignored_taken = 0;
   int    cycles = 0;
   int    gap_pct = 0;
   logic [3:0] orders_used = '0;

   // pinned expectation handed over with the beat
   logic     pin_on = 1'b0;
   draw_type pin_val = '0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      // empty tables, first base and first context
      '{KIND_SAMPLE, 2'd0, 1'b1, 16'h0000, 1'b1, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd3, 1'b0, 16'hFFFF, 1'b1, '{2'd0, 1'b0}},
      // ignored kind still restarts the sequence
      '{KIND_UNUSED, 2'd3, 1'b1, 16'hFFFF, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd0, 1'b1, 16'hFFFF, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd1, 1'b0, 16'h0000, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd1, 1'b1, 16'h5A5A, 1'b0, '{2'd0, 1'b0}},
      // context seen but never extended: no threshold met
      '{KIND_SAMPLE, 2'd2, 1'b0, 16'hFFFF, 1'b1, '{2'd0, 1'b1}},
      '{KIND_COUNT,  2'd2, 1'b1, 16'hA5A5, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd3, 1'b0, 16'h0001, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd3, 1'b0, 16'h8000, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd2, 1'b0, 16'h7FFF, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd1, 1'b0, 16'h1234, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd0, 1'b0, 16'hFFFF, 1'b0, '{2'd0, 1'b0}},
      // zero draw always lands on base 0
      '{KIND_SAMPLE, 2'd3, 1'b1, 16'h0000, 1'b1, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd0, 1'b0, 16'hFFFF, 1'b0, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd1, 1'b0, 16'h8000, 1'b0, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd2, 1'b0, 16'h0001, 1'b0, '{2'd0, 1'b0}},
      '{KIND_UNUSED, 2'd0, 1'b0, 16'h0000, 1'b0, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd3, 1'b0, 16'h3039, 1'b0, '{2'd0, 1'b0}},
      // clear keeps history; next draw sees an empty context
      '{KIND_CLEAR,  2'd3, 1'b0, 16'hFFFF, 1'b0, '{2'd0, 1'b0}},
      '{KIND_SAMPLE, 2'd0, 1'b0, 16'hFFFF, 1'b1, '{2'd0, 1'b0}},
      '{KIND_CLEAR,  2'd0, 1'b1, 16'h0000, 1'b0, '{2'd0, 1'b0}},
      '{KIND_COUNT,  2'd3, 1'b0, 16'hFFFF, 1'b0, '{2'd0, 1'b0}}
   };

   function automatic int alpha_pow(input int e);
      int p;
      p = 1;
      for (int j = 0; j < e; j++) p = p * ALPHA;
      return p;
   endfunction

   // first counter of the order-k table
   function automatic int tbl_base(input int k);
      int s;
      s = 0;
      for (int j = 0; j < k; j++) s = s + alpha_pow(j + 1);
      return s;
   endfunction

   function automatic int ctx_order();
      int m;
      m = (int'(order_reg) > ORDER_MAX) ? ORDER_MAX : int'(order_reg);
      return (seq_pos < m) ? seq_pos : m;
   endfunction

   function automatic void push_base(input int b);
      hist_word = (hist_word * ALPHA + b) % alpha_pow(ORDER_MAX);
      if (seq_pos < ORDER_MAX) seq_pos++;
   endfunction

   // apply one beat to the count tables; return the drawn base for a sample
   task automatic tally_and_draw(input logic [KIND_W-1:0] kind, input logic [BASE_W-1:0] b,
                                 input logic ns, input logic [RAND_W-1:0] rnd,
                                 output logic drew, output draw_type d);
      int              k;
      int              ctx;
      int              idx;
      int              first;
      longint unsigned ctx_n;
      longint unsigned cum;
      longint unsigned lhs;
      logic            found;
      drew = 1'b0;
      d = '0;
      if (ns) begin
         hist_word = 0;
         seq_pos = 0;
      end
      case (kind)
         KIND_CLEAR: begin
            for (idx = 0; idx < N_KMERS; idx++) kmer_tally[idx] = '0;
         end
         KIND_COUNT: begin
            if (int'(b) < ALPHA) begin
               for (k = 0; k <= ctx_order(); k++) begin
                  idx = tbl_base(k) + (hist_word % alpha_pow(k)) * ALPHA + int'(b);
                  if (kmer_tally[idx] != COUNT_TOP) kmer_tally[idx] = kmer_tally[idx] + 1'b1;
               end
               push_base(int'(b));
            end
         end
         KIND_SAMPLE: begin
            k = ctx_order();
            ctx = hist_word % alpha_pow(k);
            ctx_n = 0;
            if (k == 0) begin
               for (idx = 0; idx < ALPHA; idx++) ctx_n += kmer_tally[idx];
            end else begin
               ctx_n = kmer_tally[tbl_base(k - 1) + ctx];
            end
            lhs = ctx_n * longint'(rnd);
            first = tbl_base(k) + ctx * ALPHA;
            cum = 0;
            found = 1'b0;
            d.fell = 1'b1;
            // inverse-CDF walk, first base whose running sum reaches the draw
            for (idx = 0; idx < ALPHA; idx++) begin
               cum += kmer_tally[first + idx];
               if (!found && lhs <= cum * 64'd65535) begin
                  found = 1'b1;
                  d.base = idx[BASE_W-1:0];
                  d.fell = 1'b0;
               end
            end
            push_base(int'(d.base));
            drew = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic flag_mismatch(input string what);
      mismatches++;
      // keep the log bounded on a badly broken block
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // check result beats, then take request beats and register writes
   always @(posedge clock) begin : scoreboard
      draw_type want;
      draw_type d;
      logic     drew;
      if (reset) begin
         for (int i = 0; i < N_KMERS; i++) kmer_tally[i] = '0;
         hist_word = 0;
         seq_pos = 0;
         order_reg = CSR_W'(ORDER_MAX);
         drawn_q.delete();
      end else begin
         if (rsp_valid) begin
            if (drawn_q.size() == 0) begin
               flag_mismatch($sformatf("result beat with none pending (base %0d fell %0b)",
                                       rsp_sampled_base, rsp_fell_back));
            end else begin
               want = drawn_q.pop_front();
               draws_checked++;
               if (want.fell) fallbacks_seen++;
               if (rsp_sampled_base !== want.base)
                  flag_mismatch($sformatf("sampled_base got %0d want %0d",
                                          rsp_sampled_base, want.base));
               if (rsp_fell_back !== want.fell)
                  flag_mismatch($sformatf("fell_back got %0b want %0b",
                                          rsp_fell_back, want.fell));
            end
         end
         if (csr_we) begin
            order_reg = csr_wdata;
            orders_used[csr_wdata] = 1'b1;
         end
         if (start && !busy) begin
            tally_and_draw(req_kind, req_base, req_new_sequence, req_random, drew, d);
            if (drew) drawn_q.insert(drawn_q.size(), pin_on ? pin_val : d);
            if (req_kind == KIND_CLEAR) clears_taken++;
            if (req_kind == KIND_UNUSED) ignored_taken++;
            items_taken++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles, %0d results pending",
                  $time, cycles, drawn_q.size());
         $display("markov_kmer_count_and_sample_tb: done, errors");
         $finish;
      end
   end

   // present one beat at the falling edge and hold it until the block takes it
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BASE_W-1:0] b,
                            input logic ns, input logic [RAND_W-1:0] rnd,
                            input logic pinned, input draw_type pin);
      int taken_before;
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_kind = kind;
      req_base = b;
      req_new_sequence = ns;
      req_random = rnd;
      pin_on = pinned;
      pin_val = pin;
      start = 1'b1;
      taken_before = items_taken;
      do @(negedge clock); while (items_taken == taken_before);
   endtask

   // draw values weighted toward the ends of the range
   function automatic logic [RAND_W-1:0] pick_draw();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: return '0;
         1: return DRAW_TOP;
         2: return RAND_W'($urandom_range(15));
         3: return DRAW_TOP - RAND_W'($urandom_range(15));
         default: return RAND_W'($urandom);
      endcase
   endfunction

   // wait out pending work, then write the order register
   task automatic set_order(input logic [CSR_W-1:0] ord);
      start = 1'b0;
      while (drawn_q.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      while (busy) @(negedge clock);
      csr_wdata = ord;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly training runs and sampling runs, with some mixing, noise and clears
   task automatic random_phase(input int quota);
      int sent;
      int len;
      int sel;
      sent = 0;
      while (sent < quota) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send_item(KIND_COUNT, BASE_W'($urandom), i == 0, RAND_W'($urandom),
                         1'b0, NO_PIN);
            sent += len;
         end else if (sel < 85) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_item(KIND_SAMPLE, BASE_W'($urandom), i == 0, pick_draw(), 1'b0, NO_PIN);
            sent += len;
         end else if (sel < 94) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
               send_item($urandom_range(1) ? KIND_COUNT : KIND_SAMPLE, BASE_W'($urandom),
                         $urandom_range(9) == 0, pick_draw(), 1'b0, NO_PIN);
            sent += len;
         end else if (sel < 98) begin
            send_item(KIND_UNUSED, BASE_W'($urandom), 1'($urandom), RAND_W'($urandom),
                      1'b0, NO_PIN);
         end else begin
            send_item(KIND_CLEAR, BASE_W'($urandom), 1'($urandom), RAND_W'($urandom),
                      1'b0, NO_PIN);
            sent++;
         end
      end
   endtask

   logic [CSR_W-1:0] phase_order [N_PHASES] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd3};

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_CLEAR;
      req_base = '0;
      req_new_sequence = 1'b0;
      req_random = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed rows at the reset order
      gap_pct = 28;
      for (int i = 0; i < N_DIRECTED; i++)
         send_item(directed_rows[i].kind, directed_rows[i].base, directed_rows[i].ns,
                   directed_rows[i].rnd, directed_rows[i].pinned, directed_rows[i].pin);

      // random phases: sender gaps light, then heavy, then none
      for (int ph = 0; ph < N_PHASES; ph++) begin
         set_order(phase_order[ph]);
         gap_pct = (ph < 2) ? 28 : (ph < 4) ? 83 : 0;
         random_phase(PHASE_ITEMS);
      end

      // drain
      start = 1'b0;
      while (drawn_q.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (drawn_q.size() != 0) flag_mismatch("results still pending at the end");

      $display("took %0d beats (%0d clears, %0d ignored); checked %0d draws, %0d fallbacks",
               items_taken, clears_taken, ignored_taken, draws_checked, fallbacks_seen);
      $display("order settings written: mask %b; mismatches: %0d", orders_used, mismatches);
      if (mismatches == 0) begin
         $display("markov_kmer_count_and_sample_tb: done, clean");
      end else begin
         $display("markov_kmer_count_and_sample_tb: done, errors");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/mkcs_pkg.sv
sv/mkcs_wide_unit.sv
sv/markov_kmer_count_and_sample.sv
sv/mkcs_checker.sv
test/markov_kmer_count_and_sample_tb.sv
